### rtl/gdr_pkg.sv
package gdr_pkg;

    // geometry and number formats
    localparam int MAP_DIM_DEF = 64;
    localparam int FRAC_BITS   = 16;
    localparam int ONE_FX      = 1 << FRAC_BITS;
    localparam int TEX_SIZE    = 256;
    localparam int TEX_W       = $clog2(TEX_SIZE);

    // field widths
    localparam int POS_W   = 22;
    localparam int VEC_W   = 18;
    localparam int SCR_W   = 12;
    localparam int COL_W   = 11;
    localparam int CELL_W  = 6;
    localparam int TYPE_W  = 4;
    localparam int PERP_W  = 24;
    localparam int LH_W    = 16;
    localparam int ROW_W   = 11;

    // internal widths
    localparam int T_W       = COL_W + 2 + FRAC_BITS;
    localparam int RAY_W     = 32;
    localparam int DIV_NUM_W = 48;

    // ports
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 22;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 88;

    // register reset values
    localparam int DIR_X_RST   = 0;
    localparam int DIR_Y_RST   = 65536;
    localparam int PLANE_X_RST = 43691;
    localparam int PLANE_Y_RST = 0;
    localparam int SCR_W_RST   = 640;
    localparam int SCR_H_RST   = 480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_X,
        CFG_POS_Y,
        CFG_DIR_X,
        CFG_DIR_Y,
        CFG_PLANE_X,
        CFG_PLANE_Y,
        CFG_SCR_W,
        CFG_SCR_H
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_TDIV,
        S_RAY1,
        S_RAY2,
        S_RD,
        S_CHK,
        S_PDIV,
        S_LH,
        S_LDIV,
        S_TEX,
        S_FIN
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [RAY_W-1:0]     den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

    // first field in the highest bits
    typedef struct packed {
        logic [TEX_W-1:0]  tex_column;
        logic [ROW_W-1:0]  draw_end;
        logic [ROW_W-1:0]  draw_start;
        logic [LH_W-1:0]   line_height;
        logic [PERP_W-1:0] perp_distance;
        logic [TYPE_W-1:0] wall_type;
        logic [CELL_W-1:0] wall_col;
        logic [CELL_W-1:0] wall_row;
        logic              wall_side;
        logic              hit;
    } t_result;

endpackage

### rtl/gdr_div.sv
module gdr_div import gdr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [RAY_W-1:0]     r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [RAY_W-1:0]     r_den;

    logic [RAY_W:0]       n_sh;
    logic [RAY_W:0]       n_diff;
    logic                 n_ge;

    // restoring divide, one quotient bit per cycle
    always_comb begin
        n_sh   = {r_rem, r_quo[DIV_NUM_W-1]};
        n_diff = n_sh - {1'b0, r_den};
        n_ge   = (n_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[RAY_W-1:0] : n_sh[RAY_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], n_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

### rtl/gdr_map.sv
module gdr_map import gdr_pkg::*; #(
    parameter  int MAP_DIM = MAP_DIM_DEF,
    localparam int AW      = $clog2(MAP_DIM * MAP_DIM)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [TYPE_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [TYPE_W-1:0] o_rdata,
    output logic              o_busy
);

    localparam int DEPTH = MAP_DIM * MAP_DIM;

    logic [TYPE_W-1:0] r_mem [DEPTH];
    logic [TYPE_W-1:0] r_rdata;
    logic [AW-1:0]     r_clr_addr;
    logic              r_clr_busy;

    // clearing sweep after reset, one cell per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

### rtl/grid_dda_wall_raycaster.sv
// Grid DDA wall raycaster.
// Input stream (s_axis): tuser selects the item kind. 0 writes one map cell
// (cell_row, cell_col, cell_value), 1 casts one screen column. Only a cast
// produces a result item on the output stream (m_axis).
// Config port: i_cfg_we writes the register that i_cfg_idx selects (pos, dir,
// plane, screen size); write only while the block is idle.
// A cast that hits a wall uses the shared one-bit-per-cycle divider up to
// three times (ray parameter, wall distance, line height); for each cell
// visited the walk reads the map memory, then compares and steps. The walk
// visits at most 2*MAP_DIM+4 cells. A miss needs only the first division.
// One item is worked on at a time; tready is high only while idle.
// Reset: config registers take their defaults, then the map is swept to all
// open cells with tready low. Config writes are taken during the sweep.
// Output stall: the result sits in an output register; the next item is
// accepted meanwhile, and a finished cast waits until that register frees.
module grid_dda_wall_raycaster import gdr_pkg::*; #(
    parameter int MAP_DIM = MAP_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // column[10:0], cell_row[16:11], cell_col[22:17], cell_value[26:23], zero pad
    input  logic [IN_W-1:0]      s_axis_tdata,
    // func
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // hit[0], wall_side[1], wall_row[7:2], wall_col[13:8], wall_type[17:14],
    // perp_distance[41:18], line_height[57:42], draw_start[68:58],
    // draw_end[79:69], tex_column[87:80]
    output logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int AW    = $clog2(MAP_DIM * MAP_DIM);
    localparam int CW    = $clog2(MAP_DIM) + 2;       // signed cell coordinate
    localparam int LIMIT = 2 * MAP_DIM + 4;           // max cells walked
    localparam int KW    = $clog2(LIMIT + 1);
    localparam int NW    = FRAC_BITS + KW + 1;        // boundary distance numerator
    localparam int PW    = VEC_W + T_W;

    // config registers
    logic        [POS_W-1:0] r_pos_x, r_pos_y;
    logic signed [VEC_W-1:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic        [SCR_W-1:0] r_scr_w, r_scr_h;

    t_state r_state, n_state;

    // cast datapath
    logic signed [T_W-1:0]      r_t;
    logic signed [PW-1:0]       r_prod_x, r_prod_y;
    logic signed [RAY_W-1:0]    r_rx, r_ry;
    logic        [RAY_W-1:0]    r_ax, r_ay;
    logic        [NW-1:0]       r_nx, r_ny;
    logic        [NW+RAY_W-1:0] r_cmp_x, r_cmp_y;
    logic signed [CW-1:0]       r_cx, r_cy;
    logic        [KW-1:0]       r_k;
    logic                       r_side;
    logic                       r_found;
    logic        [TYPE_W-1:0]   r_type;
    logic        [NW-1:0]       r_last_n;
    logic        [RAY_W-1:0]    r_last_a;
    logic        [PERP_W-1:0]   r_perp;
    logic        [LH_W-1:0]     r_lh;
    logic        [RAY_W-1:0]    r_tprod;

    logic    r_m_valid;
    t_result r_m_data;

    // input unpack
    logic [COL_W-1:0]  w_in_column;
    logic [CELL_W-1:0] w_in_row, w_in_col;
    logic [TYPE_W-1:0] w_in_value;
    logic              w_in_acc;

    assign w_in_column = s_axis_tdata[10:0];
    assign w_in_row    = s_axis_tdata[16:11];
    assign w_in_col    = s_axis_tdata[22:17];
    assign w_in_value  = s_axis_tdata[26:23];
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc    = s_axis_tvalid && s_axis_tready;

    // map memory
    logic              w_map_we;
    logic [AW-1:0]     w_map_waddr, w_map_raddr;
    logic [TYPE_W-1:0] w_map_rdata;
    logic              w_map_busy;

    assign w_map_we = w_in_acc && !s_axis_tuser
                      && (32'(w_in_row) < MAP_DIM) && (32'(w_in_col) < MAP_DIM);
    assign w_map_waddr = AW'(32'(w_in_row) * MAP_DIM + 32'(w_in_col));
    assign w_map_raddr = AW'(32'(r_cx) * MAP_DIM + 32'(r_cy));

    gdr_map #(.MAP_DIM(MAP_DIM)) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_map_we),
        .i_waddr (w_map_waddr),
        .i_wdata (w_in_value),
        .i_raddr (w_map_raddr),
        .o_rdata (w_map_rdata),
        .o_busy  (w_map_busy)
    );

    // shared divider
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    gdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // helpers
    logic        [SCR_W-1:0]  w_w_eff, w_h_eff;
    logic signed [T_W-1:0]    w_q_t;
    logic signed [RAY_W-1:0]  w_rx, w_ry;
    logic                     w_map_out;
    logic                     w_wall;
    logic                     w_stepx;
    logic signed [CW-1:0]     w_sx, w_sy, w_cx_nxt, w_cy_nxt;
    logic                     w_leave;
    logic        [PERP_W-1:0] w_perp_sat;
    logic        [LH_W-1:0]   w_lh_sat;
    logic signed [PERP_W+RAY_W:0] w_tprod;
    logic        [FRAC_BITS-1:0]  w_frac;
    logic        [TEX_W-1:0]  w_tex, w_tex_m;
    logic                     w_mirror;
    logic        [LH_W:0]     w_de_sum;
    logic        [LH_W:0]     w_de_raw;
    logic        [SCR_W-1:0]  w_ds_raw;
    t_result                  w_res;
    logic                     w_load;

    assign w_w_eff = (r_scr_w == '0) ? SCR_W'(1) : r_scr_w;
    assign w_h_eff = (r_scr_h == '0) ? SCR_W'(1) : r_scr_h;
    assign w_q_t   = {1'b0, w_div_rsp.quot[T_W-2:0]};

    assign w_rx = RAY_W'(r_dir_x) + RAY_W'(r_prod_x >>> FRAC_BITS);
    assign w_ry = RAY_W'(r_dir_y) + RAY_W'(r_prod_y >>> FRAC_BITS);
    assign w_map_out = (32'(r_pos_x >> FRAC_BITS) >= MAP_DIM)
                       || (32'(r_pos_y >> FRAC_BITS) >= MAP_DIM);

    // walk step: row boundary wins a tie
    assign w_wall   = (w_map_rdata != '0);
    assign w_stepx  = (r_ax != '0) && ((r_ay == '0) || (r_cmp_x <= r_cmp_y));
    assign w_sx     = r_rx[RAY_W-1] ? {CW{1'b1}} : CW'(1);
    assign w_sy     = r_ry[RAY_W-1] ? {CW{1'b1}} : CW'(1);
    assign w_cx_nxt = w_stepx ? r_cx + w_sx : r_cx;
    assign w_cy_nxt = w_stepx ? r_cy : r_cy + w_sy;
    assign w_leave  = (w_cx_nxt < 0) || (w_cy_nxt < 0)
                      || (w_cx_nxt >= CW'(MAP_DIM)) || (w_cy_nxt >= CW'(MAP_DIM));

    assign w_perp_sat = (|w_div_rsp.quot[DIV_NUM_W-1:PERP_W])
                        ? '1 : w_div_rsp.quot[PERP_W-1:0];
    assign w_lh_sat   = (|w_div_rsp.quot[DIV_NUM_W-1:LH_W])
                        ? '1 : w_div_rsp.quot[LH_W-1:0];

    // hit point along the wall, only its fraction matters
    assign w_tprod  = $signed({1'b0, r_perp}) * (r_side ? r_rx : r_ry);
    assign w_frac   = (r_side ? r_pos_x[FRAC_BITS-1:0] : r_pos_y[FRAC_BITS-1:0])
                      + r_tprod[2*FRAC_BITS-1:FRAC_BITS];
    assign w_tex    = w_frac[FRAC_BITS-1 -: TEX_W];
    assign w_mirror = (!r_side && !r_rx[RAY_W-1] && (r_rx != '0))
                      || (r_side && r_ry[RAY_W-1]);
    assign w_tex_m  = w_mirror ? TEX_W'(TEX_SIZE - 1) - w_tex : w_tex;

    // draw rows
    assign w_ds_raw = (32'(r_lh) >= 32'(w_h_eff)) ? '0
                      : SCR_W'(w_h_eff - SCR_W'(r_lh)) >> 1;
    assign w_de_sum = (LH_W+1)'(r_lh) + (LH_W+1)'(w_h_eff);
    assign w_de_raw = ((w_de_sum >> 1) >= (LH_W+1)'(w_h_eff))
                      ? (LH_W+1)'(w_h_eff) - (LH_W+1)'(1) : (w_de_sum >> 1);

    always_comb begin
        w_res = '0;
        if (r_found) begin
            w_res.hit           = 1'b1;
            w_res.wall_side     = r_side;
            w_res.wall_row      = CELL_W'(r_cx);
            w_res.wall_col      = CELL_W'(r_cy);
            w_res.wall_type     = r_type;
            w_res.perp_distance = r_perp;
            w_res.line_height   = r_lh;
            w_res.draw_start    = (32'(w_ds_raw) > 2047) ? '1 : ROW_W'(w_ds_raw);
            w_res.draw_end      = (32'(w_de_raw) > 2047) ? '1 : ROW_W'(w_de_raw);
            w_res.tex_column    = w_tex_m;
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        w_div_req = '0;
        w_load    = 1'b0;
        unique case (r_state)
            S_CLR: begin
                if (!w_map_busy) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_in_acc && s_axis_tuser) begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = DIV_NUM_W'(w_in_column) << (FRAC_BITS + 1);
                    w_div_req.den   = RAY_W'(w_w_eff);
                    n_state         = S_TDIV;
                end
            end
            S_TDIV: begin
                if (w_div_rsp.done) n_state = S_RAY1;
            end
            S_RAY1: n_state = S_RAY2;
            S_RAY2: begin
                n_state = w_map_out ? S_FIN : S_RD;
            end
            S_RD: begin
                n_state = (r_k == KW'(LIMIT)) ? S_FIN : S_CHK;
            end
            S_CHK: begin
                if (w_wall) begin
                    if (r_k == '0) begin
                        n_state = S_LH;
                    end else begin
                        w_div_req.start = 1'b1;
                        w_div_req.num   = DIV_NUM_W'(r_last_n) << FRAC_BITS;
                        w_div_req.den   = r_last_a;
                        n_state         = S_PDIV;
                    end
                end else if ((r_ax == '0) && (r_ay == '0)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = w_leave ? S_FIN : S_RD;
                end
            end
            S_PDIV: begin
                if (w_div_rsp.done) n_state = S_LH;
            end
            S_LH: begin
                if (r_perp == '0) begin
                    n_state = S_TEX;
                end else begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = DIV_NUM_W'(w_h_eff) << FRAC_BITS;
                    w_div_req.den   = RAY_W'(r_perp);
                    n_state         = S_LDIV;
                end
            end
            S_LDIV: begin
                if (w_div_rsp.done) n_state = S_TEX;
            end
            S_TEX: n_state = S_FIN;
            S_FIN: begin
                if (!r_m_valid || m_axis_tready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_m_valid <= 1'b0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_dir_x   <= VEC_W'(DIR_X_RST);
            r_dir_y   <= VEC_W'(DIR_Y_RST);
            r_plane_x <= VEC_W'(PLANE_X_RST);
            r_plane_y <= VEC_W'(PLANE_Y_RST);
            r_scr_w   <= SCR_W'(SCR_W_RST);
            r_scr_h   <= SCR_W'(SCR_H_RST);
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_POS_X:   r_pos_x   <= i_cfg_wdata[POS_W-1:0];
                    CFG_POS_Y:   r_pos_y   <= i_cfg_wdata[POS_W-1:0];
                    CFG_DIR_X:   r_dir_x   <= i_cfg_wdata[VEC_W-1:0];
                    CFG_DIR_Y:   r_dir_y   <= i_cfg_wdata[VEC_W-1:0];
                    CFG_PLANE_X: r_plane_x <= i_cfg_wdata[VEC_W-1:0];
                    CFG_PLANE_Y: r_plane_y <= i_cfg_wdata[VEC_W-1:0];
                    CFG_SCR_W:   r_scr_w   <= i_cfg_wdata[SCR_W-1:0];
                    CFG_SCR_H:   r_scr_h   <= i_cfg_wdata[SCR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_TDIV: begin
                if (w_div_rsp.done) r_t <= w_q_t - T_W'(ONE_FX);
            end
            S_RAY1: begin
                r_prod_x <= r_plane_x * r_t;
                r_prod_y <= r_plane_y * r_t;
            end
            S_RAY2: begin
                r_rx    <= w_rx;
                r_ry    <= w_ry;
                r_ax    <= w_rx[RAY_W-1] ? RAY_W'(-w_rx) : RAY_W'(w_rx);
                r_ay    <= w_ry[RAY_W-1] ? RAY_W'(-w_ry) : RAY_W'(w_ry);
                r_nx    <= w_rx[RAY_W-1] ? NW'(r_pos_x[FRAC_BITS-1:0])
                           : NW'(ONE_FX) - NW'(r_pos_x[FRAC_BITS-1:0]);
                r_ny    <= w_ry[RAY_W-1] ? NW'(r_pos_y[FRAC_BITS-1:0])
                           : NW'(ONE_FX) - NW'(r_pos_y[FRAC_BITS-1:0]);
                r_cx    <= $signed(CW'(r_pos_x >> FRAC_BITS));
                r_cy    <= $signed(CW'(r_pos_y >> FRAC_BITS));
                r_k     <= '0;
                r_side  <= 1'b0;
                r_found <= 1'b0;
            end
            S_RD: begin
                r_cmp_x <= r_nx * r_ay;
                r_cmp_y <= r_ny * r_ax;
            end
            S_CHK: begin
                if (w_wall) begin
                    r_found <= 1'b1;
                    r_type  <= w_map_rdata;
                    r_perp  <= '0;
                end else if ((r_ax != '0) || (r_ay != '0)) begin
                    r_side <= !w_stepx;
                    r_cx   <= w_cx_nxt;
                    r_cy   <= w_cy_nxt;
                    r_k    <= r_k + KW'(1);
                    if (w_stepx) begin
                        r_last_n <= r_nx;
                        r_last_a <= r_ax;
                        r_nx     <= r_nx + NW'(ONE_FX);
                    end else begin
                        r_last_n <= r_ny;
                        r_last_a <= r_ay;
                        r_ny     <= r_ny + NW'(ONE_FX);
                    end
                end
            end
            S_PDIV: begin
                if (w_div_rsp.done) r_perp <= w_perp_sat;
            end
            S_LH: begin
                if (r_perp == '0) r_lh <= '1;
            end
            S_LDIV: begin
                if (w_div_rsp.done) r_lh <= w_lh_sat;
            end
            S_TEX: begin
                r_tprod <= w_tprod[RAY_W-1:0];
            end
            S_FIN: begin
                if (w_load) r_m_data <= w_res;
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import gdr_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE      = 20;
    localparam int WALK_MAX    = 2 * MAP_DIM_DEF + 4;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata = '0;
    logic               s_axis_tuser = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;

    grid_dda_wall_raycaster dut (.*);

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Shadow copy of the block: map, registers, pending casts
    // ---------------------------------------------------------------
    logic [TYPE_W-1:0]       map_shadow [MAP_DIM_DEF*MAP_DIM_DEF];
    logic [POS_W-1:0]        pos_x_r, pos_y_r;
    logic signed [VEC_W-1:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
    logic [SCR_W-1:0]        scr_w_r, scr_h_r;
    t_result                 pending_hits [$];

    int  errors = 0;
    int  casts_sent = 0;
    int  cells_sent = 0;
    int  hits_seen = 0;
    int  misses_seen = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;      // no idling on either side while set

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 9);
    endfunction

    // Ray cast through the shadow map: ray build, DDA walk, wall strip math.
    function automatic t_result cast_column(input logic [COL_W-1:0] col);
        t_result r;
        longint unsigned w, h, c, nx, ny, ax, ay, perp, lh, ds, de, tex;
        longint t, rx, ry, wall, cx, cy, sx, sy;
        int side, k;
        bit found, stepx;
        r = '0;
        side = 0;
        found = 1'b0;
        perp = 0;
        w = (scr_w_r == 0) ? 1 : scr_w_r;
        h = (scr_h_r == 0) ? 1 : scr_h_r;
        c = col;
        t = longint'(((2 * c) << FRAC_BITS) / w) - ONE_FX;
        rx = longint'(dir_x_r) + ((longint'(plane_x_r) * t) >>> FRAC_BITS);
        ry = longint'(dir_y_r) + ((longint'(plane_y_r) * t) >>> FRAC_BITS);
        cx = pos_x_r >> FRAC_BITS;
        cy = pos_y_r >> FRAC_BITS;
        if (cx >= MAP_DIM_DEF || cy >= MAP_DIM_DEF)
            return r;
        sx = (rx < 0) ? -1 : 1;
        sy = (ry < 0) ? -1 : 1;
        nx = (rx < 0) ? (pos_x_r & (ONE_FX - 1)) : ONE_FX - (pos_x_r & (ONE_FX - 1));
        ny = (ry < 0) ? (pos_y_r & (ONE_FX - 1)) : ONE_FX - (pos_y_r & (ONE_FX - 1));
        ax = (rx < 0) ? -rx : rx;
        ay = (ry < 0) ? -ry : ry;
        for (k = 0; k < WALK_MAX; k++) begin
            if (map_shadow[cx * MAP_DIM_DEF + cy] != 0) begin
                found = 1'b1;
                break;
            end
            if (ax == 0 && ay == 0)
                break;
            if (ax == 0)
                stepx = 1'b0;
            else if (ay == 0)
                stepx = 1'b1;
            else
                stepx = (nx * ay <= ny * ax);   // tie goes to the row boundary
            if (stepx) begin
                side = 0;
                perp = (nx << FRAC_BITS) / ax;
                nx += ONE_FX;
                cx += sx;
            end else begin
                side = 1;
                perp = (ny << FRAC_BITS) / ay;
                ny += ONE_FX;
                cy += sy;
            end
            if (cx < 0 || cy < 0 || cx >= MAP_DIM_DEF || cy >= MAP_DIM_DEF)
                break;
        end
        if (!found)
            return r;
        // viewer standing in a wall
        if (k == 0) begin
            side = 0;
            perp = 0;
        end
        if (perp > 24'hFFFFFF)
            perp = 24'hFFFFFF;
        lh = (perp == 0) ? 16'hFFFF : (h << FRAC_BITS) / perp;
        if (lh > 16'hFFFF)
            lh = 16'hFFFF;
        ds = (lh >= h) ? 0 : (h - lh) / 2;
        de = (lh + h) / 2;
        if (de >= h)
            de = h - 1;
        if (ds > 2047)
            ds = 2047;
        if (de > 2047)
            de = 2047;
        if (side == 1)
            wall = longint'(pos_x_r) + (($signed(perp) * rx) >>> FRAC_BITS);
        else
            wall = longint'(pos_y_r) + (($signed(perp) * ry) >>> FRAC_BITS);
        tex = ((wall & (ONE_FX - 1)) * TEX_SIZE) >> FRAC_BITS;
        if ((side == 0 && rx > 0) || (side == 1 && ry < 0))
            tex = TEX_SIZE - tex - 1;
        r.hit           = 1'b1;
        r.wall_side     = side[0];
        r.wall_row      = cx[CELL_W-1:0];
        r.wall_col      = cy[CELL_W-1:0];
        r.wall_type     = map_shadow[cx * MAP_DIM_DEF + cy];
        r.perp_distance = perp[PERP_W-1:0];
        r.line_height   = lh[LH_W-1:0];
        r.draw_start    = ds[ROW_W-1:0];
        r.draw_end      = de[ROW_W-1:0];
        r.tex_column    = tex[TEX_W-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    // Valid stays high between back-to-back items; it is only dropped when
    // a gap is drawn, so there is one assignment to it per time step.
    task automatic send_item(input bit cast, input logic [COL_W-1:0] col,
                             input logic [CELL_W-1:0] row, input logic [CELL_W-1:0] ccol,
                             input logic [TYPE_W-1:0] val);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cast;
        s_axis_tdata  <= {5'b0, val, ccol, row, col};
        do @(posedge i_clk); while (!s_axis_tready);
        if (cast) begin
            pending_hits.push_back(cast_column(col));
            casts_sent++;
        end else begin
            map_shadow[row * MAP_DIM_DEF + ccol] = val;
            cells_sent++;
        end
    endtask

    task automatic cast_col(input int col);
        send_item(1'b1, COL_W'(col), CELL_W'($urandom), CELL_W'($urandom),
                  TYPE_W'($urandom));
    endtask

    task automatic put_cell(input int row, input int ccol, input int val);
        send_item(1'b0, COL_W'($urandom), CELL_W'(row), CELL_W'(ccol), TYPE_W'(val));
    endtask

    // Stop sending and let every pending cast come back; a trailing map
    // write may still be in flight, hence the settle cycles.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_POS_X:   pos_x_r   = val[POS_W-1:0];
            CFG_POS_Y:   pos_y_r   = val[POS_W-1:0];
            CFG_DIR_X:   dir_x_r   = val[VEC_W-1:0];
            CFG_DIR_Y:   dir_y_r   = val[VEC_W-1:0];
            CFG_PLANE_X: plane_x_r = val[VEC_W-1:0];
            CFG_PLANE_Y: plane_y_r = val[VEC_W-1:0];
            CFG_SCR_W:   scr_w_r   = val[SCR_W-1:0];
            CFG_SCR_H:   scr_h_r   = val[SCR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_view(input int px, input int py, input int dx, input int dy,
                            input int plx, input int ply, input int sw, input int sh);
        write_reg(CFG_POS_X, CFG_W'(px));
        write_reg(CFG_POS_Y, CFG_W'(py));
        write_reg(CFG_DIR_X, CFG_W'(dx));
        write_reg(CFG_DIR_Y, CFG_W'(dy));
        write_reg(CFG_PLANE_X, CFG_W'(plx));
        write_reg(CFG_PLANE_Y, CFG_W'(ply));
        write_reg(CFG_SCR_W, CFG_W'(sw));
        write_reg(CFG_SCR_H, CFG_W'(sh));
    endtask

    // ---------------------------------------------------------------
    // Output side: random stalls, each result against the oldest cast
    // ---------------------------------------------------------------
    task automatic check_hit(input t_result got);
        t_result exp;
        if (pending_hits.size() == 0) begin
            $error("unexpected result item %h", got);
            errors++;
            return;
        end
        exp = pending_hits.pop_front();
        if (got.hit) hits_seen++; else misses_seen++;
        if (got.hit !== exp.hit) begin
            $error("hit exp %0d got %0d", exp.hit, got.hit); errors++;
        end
        if (got.wall_side !== exp.wall_side) begin
            $error("wall_side exp %0d got %0d", exp.wall_side, got.wall_side); errors++;
        end
        if (got.wall_row !== exp.wall_row) begin
            $error("wall_row exp %0d got %0d", exp.wall_row, got.wall_row); errors++;
        end
        if (got.wall_col !== exp.wall_col) begin
            $error("wall_col exp %0d got %0d", exp.wall_col, got.wall_col); errors++;
        end
        if (got.wall_type !== exp.wall_type) begin
            $error("wall_type exp %0d got %0d", exp.wall_type, got.wall_type); errors++;
        end
        if (got.perp_distance !== exp.perp_distance) begin
            $error("perp_distance exp %0d got %0d", exp.perp_distance, got.perp_distance);
            errors++;
        end
        if (got.line_height !== exp.line_height) begin
            $error("line_height exp %0d got %0d", exp.line_height, got.line_height); errors++;
        end
        if (got.draw_start !== exp.draw_start) begin
            $error("draw_start exp %0d got %0d", exp.draw_start, got.draw_start); errors++;
        end
        if (got.draw_end !== exp.draw_end) begin
            $error("draw_end exp %0d got %0d", exp.draw_end, got.draw_end); errors++;
        end
        if (got.tex_column !== exp.tex_column) begin
            $error("tex_column exp %0d got %0d", exp.tex_column, got.tex_column); errors++;
        end
    endtask

    int stall_left = 0;
    always @(posedge i_clk) begin : result_sink
        int w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            check_hit(t_result'(m_axis_tdata));
            w = draw_wait();
            stall_left <= w;
            m_axis_tready <= (w == 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d casts pending", cycles, pending_hits.size());
            $display("grid_dda_wall_raycaster verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Fresh map is all open: the default view walks straight off the map.
    task automatic test_open_map();
        cast_col(0);
        cast_col(2047);
        drain();
    endtask

    // Directed corners: tie, zero ray, viewer in a wall, field extremes.
    task automatic test_corners();
        // map cell extremes, including a write of an open cell
        put_cell(0, 63, 1);
        put_cell(63, 0, 15);
        put_cell(7, 7, 9);
        put_cell(63, 63, 0);
        drain();
        // diagonal ray from a cell center: both boundaries tie at every other step
        set_view(360448, 360448, 65536, 65536, 0, 0, 640, 480);
        cast_col(320);
        drain();
        // zero ray from an open cell
        write_reg(CFG_DIR_X, '0);
        write_reg(CFG_DIR_Y, '0);
        cast_col(5);
        drain();
        // viewer inside a wall
        put_cell(5, 5, 3);
        cast_col(100);
        put_cell(5, 5, 0);
        drain();
        // vector extremes, zero screen size, column past the width
        set_view(0, 4194303, -131072, 131071, 131071, -131072, 0, 0);
        cast_col(2047);
        cast_col(0);
        drain();
        // tall screen: draw rows saturate
        set_view(4194303, 0, 131071, -131072, -131072, 131071, 1, 4095);
        cast_col(2047);
        cast_col(1);
        drain();
    endtask

    // Phases: new view, a batch of wall edits, then many casts.
    task automatic test_random_views();
        int sw;
        for (int p = 0; p < 6; p++) begin
            if (p == 1)
                set_view(4194303, 4194303, 131071, 131071, 131071, 131071, 2048, 2048);
            else if (p == 2)
                set_view(0, 0, -131072, -131072, -131072, -131072, 1, 1);
            else if (p == 4)
                set_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         4095, 0);
            else
                set_view($urandom_range(0, 4194303), $urandom_range(0, 4194303),
                         $urandom_range(0, 262143) - 131072,
                         $urandom_range(0, 262143) - 131072,
                         $urandom_range(0, 131071) - 65536,
                         $urandom_range(0, 131071) - 65536,
                         $urandom_range(1, 2048), $urandom_range(1, 2048));
            quiet = (p % 2 == 0);
            for (int i = 0; i < 60; i++) begin
                if (i == 20) quiet = 1'b0;
                // mostly walls, some cells cleared back to open
                put_cell($urandom_range(0, 63), $urandom_range(0, 63),
                         ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 15));
            end
            sw = (scr_w_r == 0) ? 1 : scr_w_r;
            for (int i = 0; i < 130; i++) begin
                if (i == 65) drain();   // let the pipe empty mid-phase
                if (i == 30) quiet = (p % 2 == 1);
                if (i == 60) quiet = 1'b0;
                if ($urandom_range(0, 7) == 0)
                    cast_col($urandom_range(0, 2047));
                else
                    cast_col($urandom_range(0, (sw > 2048 ? 2048 : sw) - 1));
            end
            drain();
        end
    endtask

    initial begin
        pos_x_r = '0;
        pos_y_r = '0;
        dir_x_r = DIR_X_RST;
        dir_y_r = DIR_Y_RST;
        plane_x_r = PLANE_X_RST;
        plane_y_r = PLANE_Y_RST;
        scr_w_r = SCR_W_RST;
        scr_h_r = SCR_H_RST;
        foreach (map_shadow[i]) map_shadow[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_open_map();
        test_corners();
        test_random_views();
        drain();

        $display("%0d casts checked (%0d walls hit, %0d rays off the map), %0d map writes",
                 casts_sent, hits_seen, misses_seen, cells_sent);
        $display("views covered: default, tie, zero ray, in-wall, vector and screen extremes");
        if (errors == 0 && pending_hits.size() == 0)
            $display("grid_dda_wall_raycaster verification clean");
        else
            $display("grid_dda_wall_raycaster verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/gdr_pkg.sv
rtl/gdr_div.sv
rtl/gdr_map.sv
rtl/grid_dda_wall_raycaster.sv
verif/testbench.sv
